// File: sv/sfvi_pkg.sv
package sfvi_pkg;

   localparam int ROM_PAIRS   = 21;
   localparam int TABLE_PAIRS = 21;
   localparam int CURVE_COUNT = 3;
   localparam int USED_PAIRS  = (TABLE_PAIRS > ROM_PAIRS) ? ROM_PAIRS :
                                ((TABLE_PAIRS < 2) ? 2 : TABLE_PAIRS);
   localparam int SEG_COUNT   = USED_PAIRS - 1;
   localparam int PT_W        = $clog2(ROM_PAIRS);
   localparam int CURVE_W     = $clog2(CURVE_COUNT);

   localparam int VOLT_W  = 16;
   localparam int PCT_W   = 7;
   localparam int SEL_W   = 2;
   localparam int PCT_MAX = 100;
   localparam int QUO_W   = PCT_W;
   localparam int DV_W    = VOLT_W + 1;
   localparam int DY_W    = PCT_W + 1;
   localparam int PROD_W  = DV_W + DY_W;
   localparam int NUM_W   = PROD_W;
   localparam int SUM_W   = PCT_W + 2;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

   typedef enum logic [SEL_W-1:0] {
      CHEM_LFP  = 2'd0,
      CHEM_NCM  = 2'd1,
      CHEM_LFP2 = 2'd2
   } chem_type;

   localparam logic [VOLT_W-1:0] CURVE_MV [CURVE_COUNT][ROM_PAIRS] = '{
      '{16'd4200, 16'd4000, 16'd3650, 16'd3600, 16'd3500, 16'd3450, 16'd3400,
        16'd3360, 16'd3340, 16'd3320, 16'd3300, 16'd3280, 16'd3260, 16'd3240,
        16'd3220, 16'd3200, 16'd3150, 16'd3100, 16'd3000, 16'd2800, 16'd2500},
      '{16'd4200, 16'd4126, 16'd4066, 16'd3980, 16'd3920, 16'd3874, 16'd3830,
        16'd3790, 16'd3750, 16'd3710, 16'd3670, 16'd3630, 16'd3590, 16'd3550,
        16'd3510, 16'd3470, 16'd3420, 16'd3360, 16'd3300, 16'd3200, 16'd3000},
      '{16'd4200, 16'd3650, 16'd3600, 16'd3550, 16'd3500, 16'd3450, 16'd3400,
        16'd3360, 16'd3340, 16'd3320, 16'd3300, 16'd3280, 16'd3260, 16'd3240,
        16'd3220, 16'd3200, 16'd3150, 16'd3100, 16'd3000, 16'd2800, 16'd2650}
   };

   localparam logic [PCT_W-1:0] CURVE_PCT [CURVE_COUNT][ROM_PAIRS] = '{
      '{7'd100, 7'd100, 7'd99, 7'd98, 7'd96, 7'd93, 7'd90, 7'd85, 7'd80, 7'd70,
        7'd60, 7'd50, 7'd40, 7'd30, 7'd20, 7'd10, 7'd4, 7'd2, 7'd0, 7'd0, 7'd0},
      '{7'd100, 7'd100, 7'd95, 7'd90, 7'd85, 7'd80, 7'd75, 7'd70, 7'd65, 7'd60,
        7'd55, 7'd50, 7'd45, 7'd40, 7'd35, 7'd30, 7'd25, 7'd20, 7'd15, 7'd5, 7'd0},
      '{7'd100, 7'd100, 7'd98, 7'd97, 7'd96, 7'd94, 7'd90, 7'd85, 7'd80, 7'd70,
        7'd60, 7'd50, 7'd40, 7'd30, 7'd20, 7'd10, 7'd5, 7'd2, 7'd0, 7'd0, 7'd0}
   };

   typedef struct packed {
      logic                    direct;
      logic [PCT_W-1:0]        pct;
      logic signed [DV_W-1:0]  dv;
      logic signed [DY_W-1:0]  dy;
      logic signed [DV_W-1:0]  dx;
   } seg_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

endpackage

// File: sv/sfvi_front.sv
module sfvi_front import sfvi_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [VOLT_W-1:0] req_cell_voltage_mv,
   input  logic [SEL_W-1:0]  chem_sel,
   input  fifo_stat_type     fifo_stat,
   output logic              push,
   output seg_type           push_data
);

   logic [CURVE_W-1:0] curve_idx;
   logic [VOLT_W-1:0]  xs [ROM_PAIRS];
   logic [PCT_W-1:0]   ys [ROM_PAIRS];
   logic               desc;
   logic               found;
   logic [PT_W-1:0]    seg_idx;
   logic [PT_W-1:0]    seg_nxt;
   logic [VOLT_W-1:0]  x1;
   logic [VOLT_W-1:0]  x2;
   logic [PCT_W-1:0]   y1;
   logic [PCT_W-1:0]   y2;
   logic [VOLT_W-1:0]  v;
   seg_type            entry_in;
   seg_type            entry_ff;
   logic               vld_in;
   logic               vld_ff;

   always_comb begin
      unique case (chem_type'(chem_sel))
         CHEM_NCM:  curve_idx = CURVE_W'(1);
         CHEM_LFP2: curve_idx = CURVE_W'(2);
         default:   curve_idx = CURVE_W'(0);
      endcase
   end

   assign xs = CURVE_MV[curve_idx];
   assign ys = CURVE_PCT[curve_idx];
   assign v  = req_cell_voltage_mv;

   // first segment that brackets the voltage
   always_comb begin
      desc    = xs[0] >= xs[1];
      found   = 1'b0;
      seg_idx = '0;
      for (int i = SEG_COUNT - 1; i >= 0; i--) begin
         if (desc ? (v <= xs[i] && v >= xs[i+1]) : (v >= xs[i] && v <= xs[i+1])) begin
            found   = 1'b1;
            seg_idx = PT_W'(i);
         end
      end
   end

   assign seg_nxt = seg_idx + PT_W'(1);
   assign x1 = xs[seg_idx];
   assign x2 = xs[seg_nxt];
   assign y1 = ys[seg_idx];
   assign y2 = ys[seg_nxt];

   always_comb begin
      entry_in.dv     = $signed({1'b0, v}) - $signed({1'b0, x1});
      entry_in.dy     = $signed({1'b0, y2}) - $signed({1'b0, y1});
      entry_in.dx     = $signed({1'b0, x2}) - $signed({1'b0, x1});
      entry_in.direct = 1'b1;
      priority if (desc ? (v >= xs[0]) : (v <= xs[0])) begin
         entry_in.pct = ys[0];
      end else if (desc ? (v <= xs[USED_PAIRS-1]) : (v >= xs[USED_PAIRS-1])) begin
         entry_in.pct = ys[USED_PAIRS-1];
      end else if (!found) begin
         entry_in.pct = ys[0];
      end else if (x1 == x2) begin
         entry_in.pct = y1;
      end else begin
         entry_in.pct    = y1;
         entry_in.direct = 1'b0;
      end
   end

   assign req_ready = !vld_ff || !fifo_stat.full;
   assign push      = vld_ff && !fifo_stat.full;
   assign push_data = entry_ff;
   assign vld_in    = req_ready ? req_valid : vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         entry_ff <= entry_in;
      end
   end

endmodule

// File: sv/sfvi_fifo.sv
module sfvi_fifo import sfvi_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  seg_type       push_data,
   input  logic          pop,
   output seg_type       pop_data,
   output fifo_stat_type stat
);

   seg_type              slot_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ptr_ff;
   logic [FIFO_AW-1:0]   wr_ptr_in;
   logic [FIFO_AW-1:0]   rd_ptr_ff;
   logic [FIFO_AW-1:0]   rd_ptr_in;
   logic [FIFO_CW-1:0]   count_ff;
   logic [FIFO_CW-1:0]   count_in;

   assign stat.full  = count_ff == FIFO_CW'(FIFO_DEPTH);
   assign stat.empty = count_ff == '0;
   assign pop_data   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + FIFO_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + FIFO_AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + FIFO_CW'(1);
         2'b01:   count_in = count_ff - FIFO_CW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: sv/sfvi_back.sv
module sfvi_back import sfvi_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  fifo_stat_type    fifo_stat,
   input  seg_type          pop_data,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [PCT_W-1:0] rsp_soc_percent
);

   logic adv;

   // product stage
   logic                     s0_vld_ff;
   logic                     s0_direct_ff;
   logic [PCT_W-1:0]         s0_pct_ff;
   logic signed [PROD_W-1:0] s0_prod_ff;
   logic signed [DV_W-1:0]   s0_dx_ff;
   logic signed [PROD_W-1:0] prod_in;

   // magnitude stage and divider steps share one set of arrays
   logic                d_vld_ff    [QUO_W+1];
   logic                d_direct_ff [QUO_W+1];
   logic [PCT_W-1:0]    d_pct_ff    [QUO_W+1];
   logic                d_neg_ff    [QUO_W+1];
   logic [NUM_W-1:0]    d_rem_ff    [QUO_W+1];
   logic [DV_W-1:0]     d_den_ff    [QUO_W+1];
   logic [QUO_W-1:0]    d_quo_ff    [QUO_W+1];
   logic [NUM_W-1:0]    rem0_in;
   logic [DV_W-1:0]     den0_in;

   logic                    out_vld_ff;
   logic                    out_vld_in;
   logic [PCT_W-1:0]        out_pct_ff;
   logic [PCT_W-1:0]        out_pct_in;
   logic signed [SUM_W-1:0] sum;
   logic signed [SUM_W-1:0] quo_s;

   assign adv     = !out_vld_ff || rsp_ready;
   assign pop     = adv && !fifo_stat.empty;
   assign prod_in = PROD_W'(pop_data.dv) * PROD_W'(pop_data.dy);

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
      end else if (adv) begin
         s0_vld_ff <= !fifo_stat.empty;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_direct_ff <= pop_data.direct;
         s0_pct_ff    <= pop_data.pct;
         s0_prod_ff   <= prod_in;
         s0_dx_ff     <= pop_data.dx;
      end
   end

   assign rem0_in = s0_prod_ff[PROD_W-1] ? NUM_W'(-s0_prod_ff) : NUM_W'(s0_prod_ff);
   assign den0_in = s0_dx_ff[DV_W-1] ? DV_W'(-s0_dx_ff) : DV_W'(s0_dx_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff[0] <= 1'b0;
      end else if (adv) begin
         d_vld_ff[0] <= s0_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d_direct_ff[0] <= s0_direct_ff;
         d_pct_ff[0]    <= s0_pct_ff;
         d_neg_ff[0]    <= s0_prod_ff[PROD_W-1] ^ s0_dx_ff[DV_W-1];
         d_rem_ff[0]    <= rem0_in;
         d_den_ff[0]    <= den0_in;
         d_quo_ff[0]    <= '0;
      end
   end

   // restoring division, one quotient bit per step, msb first
   for (genvar j = 0; j < QUO_W; j++) begin : g_div
      logic [NUM_W-1:0] trial;
      logic             fits;
      logic [NUM_W-1:0] rem_in;
      logic [QUO_W-1:0] quo_in;

      assign trial  = NUM_W'(d_den_ff[j]) << (QUO_W - 1 - j);
      assign fits   = d_rem_ff[j] >= trial;
      assign rem_in = fits ? d_rem_ff[j] - trial : d_rem_ff[j];
      assign quo_in = d_quo_ff[j] | (QUO_W'(fits) << (QUO_W - 1 - j));

      always_ff @(posedge clock) begin
         if (reset) begin
            d_vld_ff[j+1] <= 1'b0;
         end else if (adv) begin
            d_vld_ff[j+1] <= d_vld_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            d_direct_ff[j+1] <= d_direct_ff[j];
            d_pct_ff[j+1]    <= d_pct_ff[j];
            d_neg_ff[j+1]    <= d_neg_ff[j];
            d_rem_ff[j+1]    <= rem_in;
            d_den_ff[j+1]    <= d_den_ff[j];
            d_quo_ff[j+1]    <= quo_in;
         end
      end
   end

   // add to the first point and clamp, or pass a direct entry through
   always_comb begin
      quo_s = $signed({2'b00, d_quo_ff[QUO_W]});
      sum   = $signed({2'b00, d_pct_ff[QUO_W]}) + (d_neg_ff[QUO_W] ? -quo_s : quo_s);
      priority if (d_direct_ff[QUO_W]) begin
         out_pct_in = d_pct_ff[QUO_W];
      end else if (sum < 0) begin
         out_pct_in = '0;
      end else if (sum > SUM_W'(PCT_MAX)) begin
         out_pct_in = PCT_W'(PCT_MAX);
      end else begin
         out_pct_in = sum[PCT_W-1:0];
      end
   end

   assign out_vld_in = adv ? d_vld_ff[QUO_W] : out_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_pct_ff <= out_pct_in;
      end
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_soc_percent = out_pct_ff;

endmodule

// File: sv/soc_from_voltage_interpolation.sv
// throughput: one request per cycle while rsp_ready does not stall, set by the fully pipelined 7-step divider
// a 4-entry queue separates segment lookup from the multiply/divide pipeline
// reset (synchronous, active high) empties all stages and the queue and
// sets chemistry select to the first LiFePO4 curve
module soc_from_voltage_interpolation import sfvi_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [VOLT_W-1:0] req_cell_voltage_mv,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [PCT_W-1:0]  rsp_soc_percent,
   input  logic              csr_wr_en,
   input  logic [SEL_W-1:0]  csr_wr_data
);

   logic [SEL_W-1:0] chem_ff;
   logic [SEL_W-1:0] chem_in;
   fifo_stat_type    fifo_stat;
   logic             push;
   seg_type          push_data;
   logic             pop;
   seg_type          pop_data;

   assign chem_in = csr_wr_en ? csr_wr_data : chem_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         chem_ff <= SEL_W'(CHEM_LFP);
      end else begin
         chem_ff <= chem_in;
      end
   end

   sfvi_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_cell_voltage_mv (req_cell_voltage_mv),
      .chem_sel            (chem_ff),
      .fifo_stat           (fifo_stat),
      .push                (push),
      .push_data           (push_data)
   );

   sfvi_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .stat      (fifo_stat)
   );

   sfvi_back u_back (
      .clock           (clock),
      .reset           (reset),
      .fifo_stat       (fifo_stat),
      .pop_data        (pop_data),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_soc_percent (rsp_soc_percent)
   );

`ifndef ASSERT_OFF
   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_soc_percent <= PCT_W'(PCT_MAX))
      else $error("result above full charge");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !fifo_stat.empty)
      else $error("queue popped while empty");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !fifo_stat.full)
      else $error("queue pushed while full");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");
`endif

endmodule

// File: test/soc_from_voltage_interpolation_test.sv
module soc_from_voltage_interpolation_test;
   timeunit 1ns;
   timeprecision 1ps;

   import sfvi_pkg::*;

   localparam logic [SEL_W-1:0] CHEM_UNUSED = 2'd3;
   localparam int N_CURVES        = 3;
   localparam int N_POINTS        = 21;
   localparam int MAX_GAP         = 12;
   localparam int PIPE_TAIL       = 16;
   localparam int RSP_HOLD_CYCLES = 80;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int N_PHASES        = 6;
   localparam int PHASE_ITEMS     = 90;
   localparam int N_ROWS          = 22;

   // voltage/percent knees per curve, descending voltage
   localparam int KNEE_MV [N_CURVES][N_POINTS] = '{
      '{4200, 4000, 3650, 3600, 3500, 3450, 3400, 3360, 3340, 3320, 3300,
        3280, 3260, 3240, 3220, 3200, 3150, 3100, 3000, 2800, 2500},
      '{4200, 4126, 4066, 3980, 3920, 3874, 3830, 3790, 3750, 3710, 3670,
        3630, 3590, 3550, 3510, 3470, 3420, 3360, 3300, 3200, 3000},
      '{4200, 3650, 3600, 3550, 3500, 3450, 3400, 3360, 3340, 3320, 3300,
        3280, 3260, 3240, 3220, 3200, 3150, 3100, 3000, 2800, 2650}
   };
   localparam int KNEE_PCT [N_CURVES][N_POINTS] = '{
      '{100, 100, 99, 98, 96, 93, 90, 85, 80, 70, 60,
        50, 40, 30, 20, 10, 4, 2, 0, 0, 0},
      '{100, 100, 95, 90, 85, 80, 75, 70, 65, 60, 55,
        50, 45, 40, 35, 30, 25, 20, 15, 5, 0},
      '{100, 100, 98, 97, 96, 94, 90, 85, 80, 70, 60,
        50, 40, 30, 20, 10, 5, 2, 0, 0, 0}
   };

   typedef struct packed {
      logic [SEL_W-1:0]  chem;
      logic [VOLT_W-1:0] volt;
      logic              typed;
      logic [PCT_W-1:0]  soc;
   } soc_row_type;

   logic              clock               = 1'b0;
   logic              reset               = 1'b1;
   logic              req_valid           = 1'b0;
   logic              req_ready;
   logic [VOLT_W-1:0] req_cell_voltage_mv = '0;
   logic              rsp_valid;
   logic              rsp_ready           = 1'b0;
   logic [PCT_W-1:0]  rsp_soc_percent;
   logic              csr_wr_en           = 1'b0;
   logic [SEL_W-1:0]  csr_wr_data         = '0;

   logic [PCT_W-1:0]  soc_expected [$];
   logic [SEL_W-1:0]  chem_model   = CHEM_LFP;
   int                req_gap_max  = MAX_GAP;
   int                rsp_stall_max = MAX_GAP;
   bit                rsp_hold_request = 1'b0;
   int                mismatch_count = 0;
   int                requests_seen  = 0;
   int                results_seen   = 0;
   int                idle_cycles    = 0;

   soc_from_voltage_interpolation u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_cell_voltage_mv (req_cell_voltage_mv),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_soc_percent     (rsp_soc_percent),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [PCT_W-1:0] soc_of_voltage(logic [SEL_W-1:0] chem,
                                                       logic [VOLT_W-1:0] volt);
      int c;
      int v;
      int x1, x2, y1, y2, r;
      bit desc;
      bit hit;
      c = (chem > CHEM_LFP2) ? int'(CHEM_LFP) : int'(chem);
      v = int'(volt);
      desc = KNEE_MV[c][0] >= KNEE_MV[c][1];
      if (desc) begin
         if (v >= KNEE_MV[c][0]) return PCT_W'(KNEE_PCT[c][0]);
         if (v <= KNEE_MV[c][N_POINTS-1]) return PCT_W'(KNEE_PCT[c][N_POINTS-1]);
      end else begin
         if (v <= KNEE_MV[c][0]) return PCT_W'(KNEE_PCT[c][0]);
         if (v >= KNEE_MV[c][N_POINTS-1]) return PCT_W'(KNEE_PCT[c][N_POINTS-1]);
      end
      for (int i = 0; i + 1 < N_POINTS; i++) begin
         x1 = KNEE_MV[c][i];
         x2 = KNEE_MV[c][i+1];
         y1 = KNEE_PCT[c][i];
         y2 = KNEE_PCT[c][i+1];
         hit = desc ? (v <= x1 && v >= x2) : (v >= x1 && v <= x2);
         if (hit) begin
            if (x1 == x2) return PCT_W'(y1);
            r = y1 + ((v - x1) * (y2 - y1)) / (x2 - x1);
            if (r < 0) r = 0;
            if (r > 100) r = 100;
            return r[PCT_W-1:0];
         end
      end
      return PCT_W'(KNEE_PCT[c][0]);
   endfunction

   function automatic logic [VOLT_W-1:0] pick_voltage(logic [SEL_W-1:0] chem);
      int c;
      int mode;
      int v;
      c = (chem > CHEM_LFP2) ? int'(CHEM_LFP) : int'(chem);
      mode = $urandom_range(9, 0);
      if (mode == 0) begin
         v = $urandom_range(16'hFFFF, 0);
      end else if (mode <= 3) begin
         v = KNEE_MV[c][$urandom_range(N_POINTS - 1, 0)] + $urandom_range(6, 0) - 3;
      end else begin
         v = $urandom_range(4300, 2400);
      end
      return v[VOLT_W-1:0];
   endfunction

   task automatic send_request(input logic [VOLT_W-1:0] volt, input logic [PCT_W-1:0] soc);
      int gap;
      gap = (req_gap_max == 0) ? 0 : $urandom_range(req_gap_max, 0);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_cell_voltage_mv <= volt;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      soc_expected.push_back(soc);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (soc_expected.size() != 0);
   endtask

   task automatic set_chemistry(input logic [SEL_W-1:0] chem);
      drain_results();
      repeat (PIPE_TAIL) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= chem;
      @(posedge clock);
      csr_wr_en  <= 1'b0;
      chem_model  = chem;
   endtask

   // result side: random stalls plus one long hold-off on request
   initial begin
      int stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_hold_request) begin
            rsp_ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
            rsp_hold_request = 1'b0;
         end
         stall = (rsp_stall_max == 0) ? 0 : $urandom_range(rsp_stall_max, 0);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      logic [PCT_W-1:0] want;
      if (!reset) begin
         if (req_valid && req_ready) requests_seen++;
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (soc_expected.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%t: unexpected result soc_percent=%0d", $realtime, rsp_soc_percent);
            end else begin
               want = soc_expected.pop_front();
               if (rsp_soc_percent !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("%t: soc_percent mismatch, expected %0d, got %0d",
                              $realtime, want, rsp_soc_percent);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
      else idle_cycles = idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%t: no handshake for %0d cycles, %0d results outstanding",
                  $realtime, idle_cycles, soc_expected.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      soc_row_type rows [N_ROWS];
      logic [SEL_W-1:0] phase_chem [N_PHASES];
      int phase_gap [N_PHASES];
      int phase_stall [N_PHASES];
      logic [VOLT_W-1:0] volt;

      rows = '{
         '{CHEM_LFP,    16'd0,     1'b1, 7'd0},
         '{CHEM_LFP,    16'hFFFF,  1'b1, 7'd100},
         '{CHEM_LFP,    16'd4200,  1'b1, 7'd100},
         '{CHEM_LFP,    16'd2500,  1'b1, 7'd0},
         '{CHEM_LFP,    16'h8000,  1'b1, 7'd100},
         '{CHEM_LFP,    16'h7FFF,  1'b1, 7'd100},
         '{CHEM_LFP,    16'd3330,  1'b0, 7'd0},
         '{CHEM_LFP,    16'd4199,  1'b0, 7'd0},
         '{CHEM_LFP,    16'd2501,  1'b0, 7'd0},
         '{CHEM_NCM,    16'd0,     1'b1, 7'd0},
         '{CHEM_NCM,    16'hFFFF,  1'b1, 7'd100},
         '{CHEM_NCM,    16'd3000,  1'b1, 7'd0},
         '{CHEM_NCM,    16'd4126,  1'b1, 7'd100},
         '{CHEM_NCM,    16'd3250,  1'b0, 7'd0},
         '{CHEM_NCM,    16'd3001,  1'b0, 7'd0},
         '{CHEM_LFP2,   16'd2650,  1'b1, 7'd0},
         '{CHEM_LFP2,   16'd2649,  1'b1, 7'd0},
         '{CHEM_LFP2,   16'd3925,  1'b0, 7'd0},
         '{CHEM_LFP2,   16'd3460,  1'b0, 7'd0},
         '{CHEM_UNUSED, 16'd3460,  1'b0, 7'd0},
         '{CHEM_UNUSED, 16'hFFFF,  1'b1, 7'd100},
         '{CHEM_UNUSED, 16'd0,     1'b1, 7'd0}
      };
      phase_chem  = '{CHEM_NCM, CHEM_LFP2, CHEM_UNUSED, CHEM_LFP, CHEM_LFP2, CHEM_NCM};
      phase_gap   = '{MAX_GAP, 0, MAX_GAP, 0, MAX_GAP, 0};
      phase_stall = '{MAX_GAP, MAX_GAP, 0, 0, MAX_GAP, MAX_GAP};

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // first rows run on the chemistry left by reset
      foreach (rows[i]) begin
         if (rows[i].chem != chem_model) set_chemistry(rows[i].chem);
         send_request(rows[i].volt,
                      rows[i].typed ? rows[i].soc : soc_of_voltage(chem_model, rows[i].volt));
      end

      for (int p = 0; p < N_PHASES; p++) begin
         set_chemistry(phase_chem[p]);
         req_gap_max   = phase_gap[p];
         rsp_stall_max = phase_stall[p];
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // long result hold-off with the request side still busy
            if (p == 1 && n == 30) rsp_hold_request = 1'b1;
            if (p == 3 && n == 45) drain_results();
            volt = pick_voltage(chem_model);
            send_request(volt, soc_of_voltage(chem_model, volt));
         end
      end

      drain_results();
      repeat (PIPE_TAIL) @(posedge clock);

      $display("covered %0d requests and %0d results over all four chemistry selections,",
               requests_seen, results_seen);
      $display("with a %0d-cycle result hold-off, a full drain pause and idle-free stretches",
               RSP_HOLD_CYCLES);
      if (mismatch_count == 0 && soc_expected.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches, %0d results never arrived",
                  mismatch_count, soc_expected.size());
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
